>>> rtl/mteq_pkg.sv
// Shared constants, codes and types of the timer expiry queue.
package mteq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int TIME_BITS   = 32;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int OP_W        = 2;
  localparam int SID_W       = 4;
  localparam int DELAY_W     = 31;
  localparam int REP_W       = 16;
  localparam int KIND_W      = 3;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_ADD,
    CMD_DEL
  } cmd_kind_t;

  typedef enum logic [KIND_W-1:0] {
    K_ADDED   = 3'd0,
    K_FULL    = 3'd1,
    K_DELETED = 3'd2,
    K_UNUSED  = 3'd3,
    K_EXPIRED = 3'd4
  } res_kind_t;

  typedef struct packed {
    cmd_kind_t          op;
    logic [SID_W-1:0]   slot;
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] ival;
    logic [REP_W-1:0]   reps;
  } cmd_t;

endpackage

>>> rtl/mteq_front.sv
// Front end: accept input words, classify them and queue the commands.
module mteq_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mteq_pkg::OP_W-1:0]   in_operation,
  input  logic [mteq_pkg::SID_W-1:0]  in_slot_id,
  input  logic [mteq_pkg::DELAY_W-1:0] in_first_delay,
  input  logic [mteq_pkg::DELAY_W-1:0] in_reload_interval,
  input  logic [mteq_pkg::REP_W-1:0]  in_repeat_count,
  output logic                        q_valid,
  output mteq_pkg::cmd_t              q_cmd,
  input  logic                        q_pop
);
  import mteq_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;
  cmd_t       cmd;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && (in_operation != OP_NONE);
  assign pop      = q_pop && (cnt_r != 2'd0);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    cmd.slot  = in_slot_id;
    cmd.delay = in_first_delay;
    cmd.ival  = in_reload_interval;
    cmd.reps  = in_repeat_count;
    unique case (in_operation)
      OP_ADD:  cmd.op = CMD_ADD;
      OP_DEL:  cmd.op = CMD_DEL;
      default: cmd.op = CMD_TICK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> rtl/mteq_back.sv
// Back end: slot store, time counter, expiry scan and result register.
module mteq_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  mteq_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mteq_pkg::KIND_W-1:0] out_kind,
  output logic [mteq_pkg::SID_W-1:0]  out_slot_out,
  output logic                        out_rearmed,
  output logic                        out_last_result
);
  import mteq_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SELECT, ST_UPDATE} state_t;

  state_t                 state_r, state_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_W-1:0]      best_r, best_nxt;
  logic [TIME_BITS-1:0]   best_key_r, best_key_nxt;
  logic                   found_r, found_nxt;
  logic [TIMER_SLOTS-1:0] due_r, due_nxt;
  logic [TIMER_SLOTS-1:0] valid_r, valid_nxt;
  logic [TIME_BITS-1:0]   now_r, now_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]      out_kind_r, out_kind_nxt;
  logic [SID_W-1:0]       out_slot_r, out_slot_nxt;
  logic                   out_rearm_r, out_rearm_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [TIME_BITS-1:0]   exp_r  [TIMER_SLOTS];
  logic [DELAY_W-1:0]     ival_r [TIMER_SLOTS];
  logic [REP_W-1:0]       rep_r  [TIMER_SLOTS];

  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_addr;
  logic [TIME_BITS-1:0]   wr_exp;
  logic [DELAY_W-1:0]     wr_ival;
  logic [REP_W-1:0]       wr_rep;

  logic [SLOT_W-1:0]      rd_addr;
  logic [TIME_BITS-1:0]   rd_exp;
  logic [DELAY_W-1:0]     rd_ival;
  logic [REP_W-1:0]       rd_rep;
  logic [TIME_BITS-1:0]   diff;
  logic [TIME_BITS-1:0]   key;
  logic                   due_now;
  logic [SLOT_W-1:0]      free_idx;
  logic                   full;
  logic                   out_free;
  logic                   idx_last;
  logic [REP_W-1:0]       rep_dec;
  logic                   rearm;
  logic [DELAY_W-1:0]     step;
  logic [TIMER_SLOTS-1:0] due_left;
  logic [SLOT_W-1:0]      del_idx;

  assign rd_addr  = (state_r == ST_UPDATE) ? best_r : idx_r;
  assign rd_exp   = exp_r[rd_addr];
  assign rd_ival  = ival_r[rd_addr];
  assign rd_rep   = rep_r[rd_addr];
  assign diff     = rd_exp - now_r;
  assign key      = {~diff[TIME_BITS-1], diff[TIME_BITS-2:0]};
  assign due_now  = valid_r[rd_addr] && ((diff == '0) || diff[TIME_BITS-1]);
  assign full     = &valid_r;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_last = (idx_r == SLOT_W'(TIMER_SLOTS - 1));
  assign rep_dec  = (rd_rep != '0) ? rd_rep - REP_W'(1) : rd_rep;
  assign rearm    = (rep_dec != '0) || (rd_ival != '0);
  assign step     = (rd_ival != '0) ? rd_ival : DELAY_W'(1);
  assign del_idx  = q_cmd.slot[SLOT_W-1:0];

  always_comb begin
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    due_left         = due_r;
    due_left[best_r] = 1'b0;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    best_key_nxt  = best_key_r;
    found_nxt     = found_r;
    due_nxt       = due_r;
    valid_nxt     = valid_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_rearm_nxt = out_rearm_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_exp        = rd_exp;
    wr_ival       = rd_ival;
    wr_rep        = rd_rep;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop         = 1'b1;
          out_rearm_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          unique case (q_cmd.op)
            CMD_ADD: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_kind_nxt = K_FULL;
                out_slot_nxt = '0;
              end else begin
                wr_en               = 1'b1;
                wr_addr             = free_idx;
                wr_exp              = now_r + TIME_BITS'(q_cmd.delay);
                wr_ival             = q_cmd.ival;
                wr_rep              = q_cmd.reps;
                valid_nxt[free_idx] = 1'b1;
                out_kind_nxt        = K_ADDED;
                out_slot_nxt        = SID_W'(free_idx);
              end
            end
            CMD_DEL: begin
              out_valid_nxt = 1'b1;
              out_slot_nxt  = q_cmd.slot;
              if (valid_r[del_idx]) begin
                valid_nxt[del_idx] = 1'b0;
                out_kind_nxt       = K_DELETED;
              end else begin
                out_kind_nxt = K_UNUSED;
              end
            end
            default: begin
              now_nxt   = now_r + TIME_BITS'(1);
              idx_nxt   = '0;
              due_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        due_nxt[idx_r] = due_now;
        idx_nxt        = idx_r + SLOT_W'(1);
        if (idx_last) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SELECT;
        end
      end
      ST_SELECT: begin
        if (due_r[idx_r] && (!found_r || (key < best_key_r))) begin
          found_nxt    = 1'b1;
          best_nxt     = idx_r;
          best_key_nxt = key;
        end
        idx_nxt = idx_r + SLOT_W'(1);
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = found_nxt ? ST_UPDATE : ST_IDLE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          wr_en   = 1'b1;
          wr_addr = best_r;
          wr_rep  = rep_dec;
          if (rearm) begin
            wr_exp = now_r + TIME_BITS'(step);
          end else begin
            valid_nxt[best_r] = 1'b0;
          end
          out_valid_nxt = 1'b1;
          out_kind_nxt  = K_EXPIRED;
          out_slot_nxt  = SID_W'(best_r);
          out_rearm_nxt = rearm;
          out_last_nxt  = (due_left == '0);
          due_nxt       = due_left;
          found_nxt     = 1'b0;
          idx_nxt       = '0;
          state_nxt     = (due_left == '0) ? ST_IDLE : ST_SELECT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      exp_r[wr_addr]  <= wr_exp;
      ival_r[wr_addr] <= wr_ival;
      rep_r[wr_addr]  <= wr_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      due_r       <= '0;
      valid_r     <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      due_r       <= due_nxt;
      valid_r     <= valid_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
    best_r      <= best_nxt;
    best_key_r  <= best_key_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_rearm_r <= out_rearm_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_slot_out    = out_slot_r;
  assign out_rearmed     = out_rearm_r;
  assign out_last_result = out_last_r;

endmodule

>>> rtl/multi_timer_expiry_queue_unit.sv
// Top level of the timer expiry queue: front end, command queue and back end.
//
// Input channel (in_*): one word per command: tick, add timer or delete timer.
// Operation code 3 is accepted and dropped without a result.
// Result channel (out_*): one word per add or delete; a tick gives one word per
// expired timer, in expiry order, ties to the lower slot, or no word at all.
// out_last_result marks the final word caused by a command.
// A two-entry command queue sits between the front end and the back end, so
// input words are taken while the result register still waits on out_stall.
// Add and delete words pass through the command queue and the result register.
// A tick holds the back end while it reads the slot store one slot per cycle,
// once to mark the due timers and once per result to find the earliest
// remaining one.
// The back end carries out one command at a time.
// While out_stall is high a pending result word holds and no new one is made.
// Reset clears the time counter, all slot valid bits and both channels.
module multi_timer_expiry_queue_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mteq_pkg::OP_W-1:0]    in_operation,
  input  logic [mteq_pkg::SID_W-1:0]   in_slot_id,
  input  logic [mteq_pkg::DELAY_W-1:0] in_first_delay,
  input  logic [mteq_pkg::DELAY_W-1:0] in_reload_interval,
  input  logic [mteq_pkg::REP_W-1:0]   in_repeat_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mteq_pkg::KIND_W-1:0]  out_kind,
  output logic [mteq_pkg::SID_W-1:0]   out_slot_out,
  output logic                         out_rearmed,
  output logic                         out_last_result
);
  import mteq_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  mteq_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_slot_id         (in_slot_id),
    .in_first_delay     (in_first_delay),
    .in_reload_interval (in_reload_interval),
    .in_repeat_count    (in_repeat_count),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .q_pop              (q_pop)
  );

  mteq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_slot_out    (out_slot_out),
    .out_rearmed     (out_rearmed),
    .out_last_result (out_last_result)
  );

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind != K_EXPIRED)) |-> out_last_result)
    else $error("add or delete word not marked last");

  a_rearm_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rearmed) |-> (out_kind == K_EXPIRED))
    else $error("rearm flag on non-expiry word");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == K_FULL)) |-> (out_slot_out == '0))
    else $error("refused add carries a slot");

endmodule
